// ===== rtl/footprint_obstacle_overlap_macros.svh =====
// Assertion macros for the footprint/obstacle overlap block.
// Included by the top level; no other dependencies.
`ifndef FOOTPRINT_OBSTACLE_OVERLAP_MACROS_SVH
`define FOOTPRINT_OBSTACLE_OVERLAP_MACROS_SVH
`ifndef SYNTHESIS
`define FOO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FOO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FOO_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FOO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/foo_pkg.sv =====
// Package for the footprint/obstacle overlap block: payload types and configuration indices.
// No dependencies.
package foo_pkg;
    typedef struct packed {
        logic signed [23:0] vehicle_s;
        logic signed [23:0] vehicle_l;
        logic signed [15:0] heading_cos;
        logic signed [15:0] heading_sin;
        logic signed [23:0] obstacle_s;
        logic signed [23:0] obstacle_l;
        logic        [15:0] obstacle_half_len;
        logic        [15:0] obstacle_half_wid;
        logic signed [15:0] obstacle_cos;
        logic signed [15:0] obstacle_sin;
    } t_in_item;

    typedef struct packed {
        logic hit;
    } t_out_item;

    localparam logic [1:0] CFG_INFLATION   = 2'd0;
    localparam logic [1:0] CFG_VEHICLE_LEN = 2'd1;
    localparam logic [1:0] CFG_VEHICLE_WID = 2'd2;
endpackage

// ===== rtl/foo_in_if.sv =====
// Valid/ready channel interface for input items.
// Depends on foo_pkg.
interface foo_in_if;
    logic              valid;
    logic              ready;
    foo_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/foo_out_if.sv =====
// Valid/ready channel interface for result items.
// Depends on foo_pkg.
interface foo_out_if;
    logic               valid;
    logic               ready;
    foo_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/footprint_obstacle_overlap.sv =====
// Footprint/obstacle overlap test, five-stage pipeline, one item per cycle while the output is not stalled.
// An accepted item passes through registered stages 1 to 5 and its result is presented from stage 5;
// throughput is one item per cycle when the output is not stalled, set by the pipelined multipliers.
// A stall freezes all stages; ready is high when the last stage is free or moving.
// Synchronous active-low reset clears valid bits and configuration registers.
// Depends on foo_pkg, foo_in_if, foo_out_if and the macros header.
`include "footprint_obstacle_overlap_macros.svh"
module footprint_obstacle_overlap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    foo_in_if.sink      s_in,
    foo_out_if.source   m_out
);
    import foo_pkg::*;

    logic [15:0] r_inflation, r_vlen, r_vwid;
    logic [4:0]  r_v;
    logic        adv;

    assign adv        = !r_v[4] || m_out.ready;
    assign s_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflation <= '0;
            r_vlen      <= '0;
            r_vwid      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INFLATION:   r_inflation <= i_cfg_data;
                CFG_VEHICLE_LEN: r_vlen      <= i_cfg_data;
                CFG_VEHICLE_WID: r_vwid      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[3:0], s_in.valid};
        end
    end

    // Stage 1: differences, inflation products.
    logic               r_s1_pt;
    logic signed [25:0] r_s1_tx, r_s1_ty;
    logic        [32:0] r_s1_pl, r_s1_pw;
    logic signed [15:0] r_s1_hc, r_s1_hs, r_s1_oc, r_s1_os;
    logic        [15:0] r_s1_vl, r_s1_vw;

    // Stage 2: inflated half sizes, axis dot products of the direction vectors.
    logic               r_s2_pt;
    logic signed [25:0] r_s2_tx, r_s2_ty;
    logic        [17:0] r_s2_bl, r_s2_bw;
    logic signed [15:0] r_s2_hc, r_s2_hs, r_s2_oc, r_s2_os;
    logic        [15:0] r_s2_vl, r_s2_vw;
    logic signed [32:0] r_s2_cc, r_s2_cx, r_s2_hh, r_s2_oo;

    // Stage 3: projections of the center offset on the four axes and radius products.
    logic               r_s3_pt;
    logic signed [42:0] r_s3_d [4];
    logic        [49:0] r_s3_ra [4];
    logic        [49:0] r_s3_rb [4];
    logic        [17:0] r_s3_bl, r_s3_bw;

    // Stage 4: per-axis separation flags.
    logic [3:0] r_s4_sep;
    logic       r_s4_pt, r_s4_pin;

    logic r_s5_hit;

    logic [17:0] n_bl, n_bw;
    logic [16:0] fl, fw;

    always_comb begin
        fl   = r_s1_pl[32:16];
        fw   = r_s1_pw[32:16];
        n_bl = (fl == 17'd0) ? 18'd1 : {1'b0, fl};
        n_bw = (fw == 17'd0) ? 18'd1 : {1'b0, fw};
    end

    function automatic logic [32:0] absv(input logic signed [32:0] v);
        absv = v[32] ? 33'(-v) : 33'(v);
    endfunction

    logic signed [32:0] pu [4];
    logic signed [32:0] pv [4];
    logic signed [32:0] qu [4];
    logic signed [32:0] qv [4];
    logic signed [16:0] ax [4];
    logic signed [16:0] ay [4];

    always_comb begin
        ax[0] = r_s2_hc;  ay[0] = r_s2_hs;
        ax[1] = -r_s2_hs; ay[1] = r_s2_hc;
        ax[2] = r_s2_oc;  ay[2] = r_s2_os;
        ax[3] = -r_s2_os; ay[3] = r_s2_oc;
        // Vehicle box projections: exact since axes 0,1 are its own.
        pu[0] = r_s2_hh; pv[0] = '0;
        pu[1] = '0;      pv[1] = r_s2_hh;
        pu[2] = r_s2_cc;  pv[2] = r_s2_cx;
        pu[3] = -r_s2_cx; pv[3] = r_s2_cc;
        qu[0] = r_s2_cc;  qv[0] = -r_s2_cx;
        qu[1] = r_s2_cx;  qv[1] = r_s2_cc;
        qu[2] = r_s2_oo; qv[2] = '0;
        qu[3] = '0;      qv[3] = r_s2_oo;
    end

    logic [57:0] sep_d [4];
    logic [57:0] rsum [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sep_d[k] = {(r_s3_d[k][42] ? 43'(-r_s3_d[k]) : 43'(r_s3_d[k])), 15'd0};
            rsum[k]  = 58'(r_s3_ra[k]) + 58'(r_s3_rb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_pt <= (r_vlen == 16'd0) || (r_vwid == 16'd0);
            r_s1_tx <= 26'(s_in.data.obstacle_s) - 26'(s_in.data.vehicle_s);
            r_s1_ty <= 26'(s_in.data.obstacle_l) - 26'(s_in.data.vehicle_l);
            r_s1_pl <= s_in.data.obstacle_half_len * (17'h10000 + 17'(r_inflation));
            r_s1_pw <= s_in.data.obstacle_half_wid * (17'h10000 + 17'(r_inflation));
            r_s1_hc <= s_in.data.heading_cos;  r_s1_hs <= s_in.data.heading_sin;
            r_s1_oc <= s_in.data.obstacle_cos; r_s1_os <= s_in.data.obstacle_sin;
            r_s1_vl <= r_vlen; r_s1_vw <= r_vwid;

            r_s2_pt <= r_s1_pt; r_s2_tx <= r_s1_tx; r_s2_ty <= r_s1_ty;
            r_s2_bl <= n_bl; r_s2_bw <= n_bw;
            r_s2_hc <= r_s1_hc; r_s2_hs <= r_s1_hs; r_s2_oc <= r_s1_oc; r_s2_os <= r_s1_os;
            r_s2_vl <= r_s1_vl; r_s2_vw <= r_s1_vw;
            r_s2_cc <= 33'(r_s1_hc*r_s1_oc) + 33'(r_s1_hs*r_s1_os);
            r_s2_cx <= 33'(r_s1_hc*r_s1_os) - 33'(r_s1_hs*r_s1_oc);
            r_s2_hh <= 33'(r_s1_hc*r_s1_hc) + 33'(r_s1_hs*r_s1_hs);
            r_s2_oo <= 33'(r_s1_oc*r_s1_oc) + 33'(r_s1_os*r_s1_os);

            r_s3_pt <= r_s2_pt; r_s3_bl <= r_s2_bl; r_s3_bw <= r_s2_bw;
            for (int k = 0; k < 4; k++) begin
                r_s3_d[k]  <= 43'(r_s2_tx*ax[k]) + 43'(r_s2_ty*ay[k]);
                r_s3_ra[k] <= 50'(r_s2_vl*absv(pu[k])) + 50'(r_s2_vw*absv(pv[k]));
                r_s3_rb[k] <= 50'({r_s2_bl, 1'b0}*absv(qu[k]))
                            + 50'({r_s2_bw, 1'b0}*absv(qv[k]));
            end

            for (int k = 0; k < 4; k++) r_s4_sep[k] <= sep_d[k] > rsum[k];
            // Point test in the obstacle frame: |d| on axes 2 and 3 against the inflated half sizes.
            r_s4_pt  <= r_s3_pt;
            r_s4_pin <= ((r_s3_d[2][42] ? 43'(-r_s3_d[2]) : 43'(r_s3_d[2]))
                         <= 43'({r_s3_bl, 14'd0}))
                     && ((r_s3_d[3][42] ? 43'(-r_s3_d[3]) : 43'(r_s3_d[3]))
                         <= 43'({r_s3_bw, 14'd0}));

            r_s5_hit <= r_s4_pt ? r_s4_pin : (r_s4_sep == 4'd0);
        end
    end

    assign m_out.valid    = r_v[4];
    assign m_out.data.hit = r_s5_hit;

    `FOO_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v[4] && !m_out.ready, r_v[4])
    `FOO_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !r_v[4], s_in.ready)
    `FOO_ASSERT_NEXT(a_flow, i_clk, i_rst_n, s_in.valid && s_in.ready, r_v[0])
endmodule
